[sv/nhmr_pkg.sv]
// Shared types and constants for the egress next-hop MAC resolver.
`default_nettype none
package nhmr_pkg;

    localparam int ARP_ENTRIES_DEF    = 64;
    localparam int NUM_INTERFACES_DEF = 16;

    localparam int IFACE_ID_W = 4;
    localparam int IP_W       = 32;
    localparam int MAC_W      = 48;
    localparam int BYTE_SUM_W = 10;   // sum of four bytes, at most 1020
    localparam int ID_EXT_W   = 9;    // holds any interface count up to 256
    localparam int S_TDATA_W  = 96;
    localparam int M_TDATA_W  = 104;

    typedef enum logic [2:0] {
        V_FORWARD  = 3'd0,
        V_NO_IFACE = 3'd1,
        V_DOWN     = 3'd2,
        V_RESOLVE  = 3'd3,
        V_WRITTEN  = 3'd4
    } verdict_t;

    typedef enum logic {
        OP_SEND     = 1'b0,
        OP_IFACE_WR = 1'b1
    } opcode_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_INDEX,
        ST_READ,
        ST_EVAL
    } state_t;

    // Input beat payload, last declared field in the lowest bits
    typedef struct packed {
        logic [6:0]            pad;
        logic                  iface_up;
        logic                  iface_present;
        logic                  arp_broadcast;
        logic                  arp_known;
        logic                  openflow_pkt;
        logic [MAC_W-1:0]      mac_value;
        logic [IP_W-1:0]       next_hop_ip;
        logic [IFACE_ID_W-1:0] if_index;
    } in_data_t;

    // Output beat payload, last declared field in the lowest bits
    typedef struct packed {
        logic [MAC_W-1:0]      dst_mac;
        logic                  set_src;
        logic [MAC_W-1:0]      src_mac;
        logic [IFACE_ID_W-1:0] out_iface;
        verdict_t              verdict;
    } out_data_t;

    typedef struct packed {
        logic             wr_en;
        logic             present;
        logic             up;
        logic [MAC_W-1:0] mac;
    } iface_wr_t;

    typedef struct packed {
        logic             exists;
        logic             is_up;
        logic [MAC_W-1:0] mac;
    } iface_info_t;

    typedef struct packed {
        logic             wr_en;
        logic [IP_W-1:0]  ip;
        logic [MAC_W-1:0] mac;
    } arp_wr_t;

    typedef struct packed {
        logic             valid;
        logic [IP_W-1:0]  ip;
        logic [MAC_W-1:0] mac;
    } arp_row_t;

endpackage
`default_nettype wire

[sv/nhmr_index.sv]
// Cache index unit: byte sum of the next hop address modulo the entry count.
`default_nettype none
module nhmr_index #(
    parameter int ARP_ENTRIES = nhmr_pkg::ARP_ENTRIES_DEF
) (
    input  wire logic                               clk,
    input  wire logic [nhmr_pkg::IP_W-1:0]          ip,
    output logic      [$clog2(ARP_ENTRIES)-1:0]     idx
);
    import nhmr_pkg::*;

    localparam int ARP_IDX_W = $clog2(ARP_ENTRIES);
    localparam int SUM_W     = BYTE_SUM_W;
    localparam int RECIP_SH  = 20;
    localparam int PROD_W    = SUM_W + RECIP_SH;
    // floor(2^20 / N): quotient comes out exact or one low for sums below 1024
    localparam logic [RECIP_SH-1:0] RECIP = RECIP_SH'((1 << RECIP_SH) / ARP_ENTRIES);
    localparam logic [PROD_W-1:0]   N_C   = PROD_W'(ARP_ENTRIES);

    logic [SUM_W-1:0]  sum;
    logic [SUM_W-1:0]  sum_reg;
    logic [PROD_W-1:0] prod_next;
    logic [PROD_W-1:0] prod_reg;
    logic [SUM_W-1:0]  quot;
    logic [PROD_W-1:0] quot_n;
    logic [PROD_W-1:0] rem;
    logic [PROD_W-1:0] rem_fix;

    assign sum = SUM_W'(ip[31:24]) + SUM_W'(ip[23:16]) + SUM_W'(ip[15:8]) + SUM_W'(ip[7:0]);
    assign prod_next = PROD_W'(sum) * PROD_W'(RECIP);

    always_ff @(posedge clk)
    begin
        sum_reg  <= sum;
        prod_reg <= prod_next;
    end

    assign quot    = prod_reg[PROD_W-1:RECIP_SH];
    assign quot_n  = PROD_W'(quot) * N_C;
    assign rem     = PROD_W'(sum_reg) - quot_n;
    assign rem_fix = (rem >= N_C) ? (rem - N_C) : rem;
    assign idx     = rem_fix[ARP_IDX_W-1:0];

endmodule
`default_nettype wire

[sv/nhmr_iface_table.sv]
// Interface table: presence and up flags in flops, interface MACs in a RAM.
`default_nettype none
module nhmr_iface_table #(
    parameter int NUM_INTERFACES = nhmr_pkg::NUM_INTERFACES_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic [nhmr_pkg::IFACE_ID_W-1:0]     id,
    input  wire logic                                rd_en,
    input  wire nhmr_pkg::iface_wr_t                 wr,
    output nhmr_pkg::iface_info_t                    info
);
    import nhmr_pkg::*;

    localparam int IF_IDX_W = (NUM_INTERFACES > 1) ? $clog2(NUM_INTERFACES) : 1;

    logic [ID_EXT_W-1:0] id_ext;
    logic                id_ok;
    logic [IF_IDX_W-1:0] idx;

    logic [NUM_INTERFACES-1:0] exists_reg;
    logic [NUM_INTERFACES-1:0] up_reg;
    logic [MAC_W-1:0]          mac_mem [NUM_INTERFACES];
    iface_info_t               info_reg;

    assign id_ext = ID_EXT_W'(id);
    assign id_ok  = (id_ext < ID_EXT_W'(NUM_INTERFACES));
    assign idx    = id_ext[IF_IDX_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exists_reg <= '0;
            up_reg     <= '0;
        end
        else if (wr.wr_en && id_ok)
        begin
            exists_reg[idx] <= wr.present;
            up_reg[idx]     <= wr.up;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.wr_en && id_ok)
            mac_mem[idx] <= wr.mac;
    end

    // an out-of-range id reads as an absent interface
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            info_reg.exists <= id_ok && exists_reg[idx];
            info_reg.is_up  <= up_reg[idx];
            info_reg.mac    <= mac_mem[idx];
        end
    end

    assign info = info_reg;

endmodule
`default_nettype wire

[sv/nhmr_arp_cache.sv]
// Direct-mapped ARP cache RAM with a clearing sweep after reset.
`default_nettype none
module nhmr_arp_cache #(
    parameter int ARP_ENTRIES = nhmr_pkg::ARP_ENTRIES_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic [$clog2(ARP_ENTRIES)-1:0]     idx,
    input  wire logic                               rd_en,
    input  wire nhmr_pkg::arp_wr_t                  wr,
    output nhmr_pkg::arp_row_t                      rd_row,
    output logic                                    ready
);
    import nhmr_pkg::*;

    localparam int ARP_IDX_W = $clog2(ARP_ENTRIES);
    localparam logic [ARP_IDX_W-1:0] LAST_IDX = ARP_IDX_W'(ARP_ENTRIES - 1);

    arp_row_t             mem [ARP_ENTRIES];
    arp_row_t             rd_row_reg;
    logic                 clearing_reg;
    logic [ARP_IDX_W-1:0] clr_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end
        else if (clearing_reg)
        begin
            if (clr_cnt_reg == LAST_IDX)
                clearing_reg <= 1'b0;
            else
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clearing_reg)
            mem[clr_cnt_reg] <= '0;
        else if (wr.wr_en)
            mem[idx] <= '{valid: 1'b1, ip: wr.ip, mac: wr.mac};
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_row_reg <= mem[idx];
    end

    assign rd_row = rd_row_reg;
    assign ready  = !clearing_reg;

endmodule
`default_nettype wire

[sv/egress_next_hop_mac_resolver.sv]
// Top level: item sequencer, resolve decision and output register.
//
//   channel  | dir | handshake         | payload
//   ---------+-----+-------------------+------------------------------------------
//   s        | in  | s_tvalid/s_tready | s_tuser opcode, s_tdata header fields
//   m        | out | m_tvalid/m_tready | m_tdata verdict and rewritten MACs
//
// Each beat goes through accept, interface table read, cache read and decide, in that order.
// The two single-port RAM reads and the registered index unit set that sequence.
// After reset the cache is swept clear entry by entry; s_tready stays low meanwhile.
// A finished result waits in the output register; the next beat is taken meanwhile,
// and the decide step holds only while that register is still full and stalled.
`default_nettype none
module egress_next_hop_mac_resolver #(
    parameter int ARP_ENTRIES    = nhmr_pkg::ARP_ENTRIES_DEF,
    parameter int NUM_INTERFACES = nhmr_pkg::NUM_INTERFACES_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // if_index, next_hop_ip, mac_value, openflow_pkt, arp_known, arp_broadcast,
    // iface_present, iface_up, zero fill
    input  wire logic [nhmr_pkg::S_TDATA_W-1:0]    s_tdata,
    // opcode
    input  wire logic                              s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // verdict, out_iface, src_mac, set_src, dst_mac
    output logic      [nhmr_pkg::M_TDATA_W-1:0]    m_tdata
);
    import nhmr_pkg::*;

    localparam int ARP_IDX_W = $clog2(ARP_ENTRIES);

    state_t    state_reg;
    state_t    state_next;
    in_data_t  item_reg;
    opcode_t   opcode_reg;
    out_data_t out_reg;
    out_data_t out_next;
    logic      out_valid_reg;
    logic      out_valid_next;
    logic      accept;
    logic      eval_go;

    logic [ARP_IDX_W-1:0] arp_idx;
    logic                 arp_rd_en;
    logic                 arp_ready;
    arp_wr_t              arp_wr;
    arp_row_t             arp_row;
    logic                 iface_rd_en;
    iface_wr_t            iface_wr;
    iface_info_t          iface_info;

    nhmr_index #(
        .ARP_ENTRIES(ARP_ENTRIES)
    ) u_index (
        .clk (clk),
        .ip  (item_reg.next_hop_ip),
        .idx (arp_idx)
    );

    nhmr_iface_table #(
        .NUM_INTERFACES(NUM_INTERFACES)
    ) u_iface (
        .clk   (clk),
        .rst_n (rst_n),
        .id    (item_reg.if_index),
        .rd_en (iface_rd_en),
        .wr    (iface_wr),
        .info  (iface_info)
    );

    nhmr_arp_cache #(
        .ARP_ENTRIES(ARP_ENTRIES)
    ) u_cache (
        .clk    (clk),
        .rst_n  (rst_n),
        .idx    (arp_idx),
        .rd_en  (arp_rd_en),
        .wr     (arp_wr),
        .rd_row (arp_row),
        .ready  (arp_ready)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg   <= in_data_t'(s_tdata);
            opcode_reg <= opcode_t'(s_tuser);
        end
        if (eval_go)
            out_reg <= out_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        iface_rd_en = 1'b0;
        arp_rd_en   = 1'b0;
        eval_go     = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (arp_ready)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_INDEX;
            end
            ST_INDEX:
            begin
                iface_rd_en = 1'b1;
                state_next  = ST_READ;
            end
            ST_READ:
            begin
                arp_rd_en  = 1'b1;
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    eval_go    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Decision on the data read back from both tables, and the table write enables
    always_comb
    begin
        out_next.verdict   = V_FORWARD;
        out_next.out_iface = item_reg.if_index;
        out_next.src_mac   = '0;
        out_next.set_src   = 1'b0;
        out_next.dst_mac   = '0;
        iface_wr.wr_en     = 1'b0;
        iface_wr.present   = item_reg.iface_present;
        iface_wr.up        = item_reg.iface_up;
        iface_wr.mac       = item_reg.mac_value;
        arp_wr.wr_en       = 1'b0;
        arp_wr.ip          = item_reg.next_hop_ip;
        arp_wr.mac         = item_reg.mac_value;

        if (opcode_reg == OP_IFACE_WR)
        begin
            out_next.verdict = V_WRITTEN;
            iface_wr.wr_en   = eval_go;
        end
        else if (!iface_info.exists)
            out_next.verdict = V_NO_IFACE;
        else if (!iface_info.is_up)
            out_next.verdict = V_DOWN;
        else if (item_reg.openflow_pkt)
            out_next.dst_mac = item_reg.mac_value;
        else
        begin
            out_next.src_mac = iface_info.mac;
            out_next.set_src = 1'b1;
            out_next.dst_mac = item_reg.mac_value;
            if (item_reg.arp_known)
                arp_wr.wr_en = eval_go;
            else if (!item_reg.arp_broadcast)
            begin
                if (arp_row.valid && (arp_row.ip == item_reg.next_hop_ip))
                    out_next.dst_mac = arp_row.mac;
                else
                    out_next.verdict = V_RESOLVE;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (eval_go)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

endmodule
`default_nettype wire
